### design/lobm_pkg.sv
// Shared types and constants for the limit order book matcher.
// No dependencies.
package lobm_pkg;
    localparam int QTY_W  = 24;
    localparam int ID_W   = 32;
    localparam int KIND_W = 3;

    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [QTY_W-1:0]  qty_t;
    typedef logic [ID_W-1:0]   id_t;

    localparam kind_t KIND_ACCEPT    = 3'd0;
    localparam kind_t KIND_TRADE     = 3'd1;
    localparam kind_t KIND_CANCELLED = 3'd2;
    localparam kind_t KIND_REJECT    = 3'd3;
    localparam kind_t KIND_NOT_FOUND = 3'd4;

    localparam id_t FIRST_ID = 32'd1;
endpackage

### design/lobm_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

### design/limit_order_book_matcher.sv
// Limit order book matcher top level: bid and ask books in two RAMs.
// Depends on lobm_pkg and lobm_ram.
//
//   channel | direction | handshake          | payload
//   in      | request   | in_valid/in_stall  | cmd is_buy limit_price quantity cancel_id
//   out     | result    | out_valid/out_stall| kind order_id trade_qty trade_price
//           |           |                    | buy_id sell_id last
//
// One request at a time. A cancel scans the bid book, then the ask book, through the
// RAM read port. An insert runs a best-order search of the opposite book before
// each trade, then rests any remainder and issues the final result.
// Reset clears the valid bits and sets the next id to one; RAM needs no clear.
// A stalled output holds the engine in its trade or final state until the result is taken.
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = 32,
    parameter int PRICE_BITS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      cmd,
    input  logic                      is_buy,
    input  logic [PRICE_BITS-1:0]     limit_price,
    input  lobm_pkg::qty_t            quantity,
    input  lobm_pkg::id_t             cancel_id,
    output logic                      out_valid,
    input  logic                      out_stall,
    output lobm_pkg::kind_t           kind,
    output lobm_pkg::id_t             order_id,
    output lobm_pkg::qty_t            trade_qty,
    output logic [PRICE_BITS-1:0]     trade_price,
    output lobm_pkg::id_t             buy_id,
    output lobm_pkg::id_t             sell_id,
    output logic                      last
);
    localparam int IW = $clog2(BOOK_DEPTH);
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int EW = PRICE_BITS + lobm_pkg::QTY_W + lobm_pkg::ID_W;
    localparam logic [CW-1:0] CNT_END = CW'(BOOK_DEPTH);
    localparam logic [IW-1:0] IDX_LAST = IW'(BOOK_DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CSCAN = 3'd1;
    localparam logic [2:0] ST_BSCAN = 3'd2;
    localparam logic [2:0] ST_TRADE = 3'd3;
    localparam logic [2:0] ST_REST  = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [BOOK_DEPTH-1:0] bid_valid_reg, bid_valid_next;
    logic [BOOK_DEPTH-1:0] ask_valid_reg, ask_valid_next;
    lobm_pkg::id_t next_id_reg, next_id_next;
    lobm_pkg::id_t id_reg, id_next;
    lobm_pkg::id_t cid_reg, cid_next;
    logic buy_reg, buy_next;
    logic [PRICE_BITS-1:0] price_reg, price_next;
    lobm_pkg::qty_t rem_reg, rem_next;
    logic sel_ask_reg, sel_ask_next;
    logic [CW-1:0] iss_reg, iss_next;
    logic p_vld_reg, p_vld_next;
    logic [IW-1:0] p_idx_reg, p_idx_next;
    logic best_found_reg, best_found_next;
    logic [PRICE_BITS-1:0] best_price_reg, best_price_next;
    lobm_pkg::qty_t best_qty_reg, best_qty_next;
    lobm_pkg::id_t best_order_reg, best_order_next;
    lobm_pkg::id_t best_age_reg, best_age_next;
    logic [IW-1:0] best_slot_reg, best_slot_next;
    lobm_pkg::kind_t fkind_reg, fkind_next;

    logic out_valid_reg, out_valid_next;
    lobm_pkg::kind_t kind_reg, kind_next;
    lobm_pkg::id_t order_id_reg, order_id_next;
    lobm_pkg::qty_t trade_qty_reg, trade_qty_next;
    logic [PRICE_BITS-1:0] trade_price_reg, trade_price_next;
    lobm_pkg::id_t buy_id_reg, buy_id_next;
    lobm_pkg::id_t sell_id_reg, sell_id_next;
    logic last_reg, last_next;

    logic [IW-1:0] raddr;
    logic bid_we, ask_we;
    logic [IW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] bid_rdata, ask_rdata, rd;
    logic [PRICE_BITS-1:0] rd_price;
    lobm_pkg::qty_t rd_qty;
    lobm_pkg::id_t rd_order, rd_age;
    logic rd_valid, better, crosses, out_free;
    lobm_pkg::qty_t trade_q, left_q;
    logic [BOOK_DEPTH-1:0] own_valid;
    logic free_found;
    logic [IW-1:0] free_slot;

    lobm_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_bid_ram (
        .clk(clk), .we(bid_we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(bid_rdata)
    );

    lobm_ram #(.WIDTH(EW), .DEPTH(BOOK_DEPTH)) u_ask_ram (
        .clk(clk), .we(ask_we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(ask_rdata)
    );

    assign rd       = sel_ask_reg ? ask_rdata : bid_rdata;
    assign rd_price = rd[EW-1 -: PRICE_BITS];
    assign rd_qty   = rd[lobm_pkg::ID_W +: lobm_pkg::QTY_W];
    assign rd_order = rd[lobm_pkg::ID_W-1:0];
    assign rd_age   = next_id_reg - rd_order;
    assign rd_valid = sel_ask_reg ? ask_valid_reg[p_idx_reg] : bid_valid_reg[p_idx_reg];
    assign raddr    = iss_reg[IW-1:0];
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if (rd_price == best_price_reg)
        begin
            better = rd_age > best_age_reg;
        end
        else if (!buy_reg)
        begin
            better = rd_price > best_price_reg;
        end
        else
        begin
            better = rd_price < best_price_reg;
        end
    end

    assign crosses = buy_reg ? !(price_reg < best_price_reg) : !(best_price_reg < price_reg);
    assign trade_q = (rem_reg < best_qty_reg) ? rem_reg : best_qty_reg;
    assign left_q  = best_qty_reg - trade_q;
    assign own_valid = buy_reg ? bid_valid_reg : ask_valid_reg;

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = BOOK_DEPTH - 1; i >= 0; i--)
        begin
            if (!own_valid[i])
            begin
                free_found = 1'b1;
                free_slot  = IW'(i);
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        bid_valid_next   = bid_valid_reg;
        ask_valid_next   = ask_valid_reg;
        next_id_next     = next_id_reg;
        id_next          = id_reg;
        cid_next         = cid_reg;
        buy_next         = buy_reg;
        price_next       = price_reg;
        rem_next         = rem_reg;
        sel_ask_next     = sel_ask_reg;
        iss_next         = iss_reg;
        p_vld_next       = 1'b0;
        p_idx_next       = p_idx_reg;
        best_found_next  = best_found_reg;
        best_price_next  = best_price_reg;
        best_qty_next    = best_qty_reg;
        best_order_next  = best_order_reg;
        best_age_next    = best_age_reg;
        best_slot_next   = best_slot_reg;
        fkind_next       = fkind_reg;
        out_valid_next   = out_valid_reg && out_stall;
        kind_next        = kind_reg;
        order_id_next    = order_id_reg;
        trade_qty_next   = trade_qty_reg;
        trade_price_next = trade_price_reg;
        buy_id_next      = buy_id_reg;
        sell_id_next     = sell_id_reg;
        last_next        = last_reg;
        bid_we           = 1'b0;
        ask_we           = 1'b0;
        waddr            = best_slot_reg;
        wdata            = {best_price_reg, left_q, best_order_reg};
        in_stall         = (state_reg != ST_IDLE);

        if ((state_reg == ST_CSCAN || state_reg == ST_BSCAN) && iss_reg != CNT_END)
        begin
            p_vld_next = 1'b1;
            p_idx_next = iss_reg[IW-1:0];
            iss_next   = iss_reg + CW'(1);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    iss_next        = '0;
                    p_vld_next      = 1'b0;
                    best_found_next = 1'b0;
                    cid_next        = cancel_id;
                    buy_next        = is_buy;
                    price_next      = limit_price;
                    rem_next        = quantity;
                    if (cmd)
                    begin
                        sel_ask_next = 1'b0;
                        state_next   = ST_CSCAN;
                    end
                    else
                    begin
                        id_next      = next_id_reg;
                        next_id_next = next_id_reg + lobm_pkg::ID_W'(1);
                        sel_ask_next = is_buy;
                        fkind_next   = lobm_pkg::KIND_ACCEPT;
                        state_next   = (quantity == '0) ? ST_FINAL : ST_BSCAN;
                    end
                end
            end
            ST_CSCAN:
            begin
                if (p_vld_reg)
                begin
                    if (rd_valid && rd_order == cid_reg)
                    begin
                        if (sel_ask_reg)
                        begin
                            ask_valid_next[p_idx_reg] = 1'b0;
                        end
                        else
                        begin
                            bid_valid_next[p_idx_reg] = 1'b0;
                        end
                        fkind_next = lobm_pkg::KIND_CANCELLED;
                        id_next    = cid_reg;
                        state_next = ST_FINAL;
                    end
                    else if (p_idx_reg == IDX_LAST)
                    begin
                        iss_next   = '0;
                        p_vld_next = 1'b0;
                        if (sel_ask_reg)
                        begin
                            fkind_next = lobm_pkg::KIND_NOT_FOUND;
                            id_next    = cid_reg;
                            state_next = ST_FINAL;
                        end
                        else
                        begin
                            sel_ask_next = 1'b1;
                        end
                    end
                end
            end
            ST_BSCAN:
            begin
                if (p_vld_reg)
                begin
                    if (rd_valid && (!best_found_reg || better))
                    begin
                        best_found_next = 1'b1;
                        best_price_next = rd_price;
                        best_qty_next   = rd_qty;
                        best_order_next = rd_order;
                        best_age_next   = rd_age;
                        best_slot_next  = p_idx_reg;
                    end
                    if (p_idx_reg == IDX_LAST)
                    begin
                        state_next = ST_TRADE;
                    end
                end
            end
            ST_TRADE:
            begin
                if (!best_found_reg || !crosses)
                begin
                    state_next = ST_REST;
                end
                else if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    kind_next        = lobm_pkg::KIND_TRADE;
                    order_id_next    = id_reg;
                    trade_qty_next   = trade_q;
                    trade_price_next = buy_reg ? best_price_reg : price_reg;
                    buy_id_next      = buy_reg ? id_reg : best_order_reg;
                    sell_id_next     = buy_reg ? best_order_reg : id_reg;
                    last_next        = 1'b0;
                    bid_we           = !sel_ask_reg;
                    ask_we           = sel_ask_reg;
                    if (left_q == '0)
                    begin
                        if (sel_ask_reg)
                        begin
                            ask_valid_next[best_slot_reg] = 1'b0;
                        end
                        else
                        begin
                            bid_valid_next[best_slot_reg] = 1'b0;
                        end
                    end
                    rem_next        = rem_reg - trade_q;
                    iss_next        = '0;
                    p_vld_next      = 1'b0;
                    best_found_next = 1'b0;
                    state_next      = (rem_reg == trade_q) ? ST_FINAL : ST_BSCAN;
                end
            end
            ST_REST:
            begin
                if (free_found)
                begin
                    waddr  = free_slot;
                    wdata  = {price_reg, rem_reg, id_reg};
                    bid_we = buy_reg;
                    ask_we = !buy_reg;
                    if (buy_reg)
                    begin
                        bid_valid_next[free_slot] = 1'b1;
                    end
                    else
                    begin
                        ask_valid_next[free_slot] = 1'b1;
                    end
                end
                else
                begin
                    fkind_next = lobm_pkg::KIND_REJECT;
                end
                state_next = ST_FINAL;
            end
            ST_FINAL:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    kind_next        = fkind_reg;
                    order_id_next    = id_reg;
                    trade_qty_next   = '0;
                    trade_price_next = '0;
                    buy_id_next      = '0;
                    sell_id_next     = '0;
                    last_next        = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bid_valid_reg <= '0;
            ask_valid_reg <= '0;
            next_id_reg   <= lobm_pkg::FIRST_ID;
            iss_reg       <= '0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bid_valid_reg <= bid_valid_next;
            ask_valid_reg <= ask_valid_next;
            next_id_reg   <= next_id_next;
            iss_reg       <= iss_next;
            p_vld_reg     <= p_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg          <= id_next;
        cid_reg         <= cid_next;
        buy_reg         <= buy_next;
        price_reg       <= price_next;
        rem_reg         <= rem_next;
        sel_ask_reg     <= sel_ask_next;
        p_idx_reg       <= p_idx_next;
        best_found_reg  <= best_found_next;
        best_price_reg  <= best_price_next;
        best_qty_reg    <= best_qty_next;
        best_order_reg  <= best_order_next;
        best_age_reg    <= best_age_next;
        best_slot_reg   <= best_slot_next;
        fkind_reg       <= fkind_next;
        kind_reg        <= kind_next;
        order_id_reg    <= order_id_next;
        trade_qty_reg   <= trade_qty_next;
        trade_price_reg <= trade_price_next;
        buy_id_reg      <= buy_id_next;
        sell_id_reg     <= sell_id_next;
        last_reg        <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign order_id    = order_id_reg;
    assign trade_qty   = trade_qty_reg;
    assign trade_price = trade_price_reg;
    assign buy_id      = buy_id_reg;
    assign sell_id     = sell_id_reg;
    assign last        = last_reg;
endmodule

### verif/tb_limit_order_book_matcher.sv
// Testbench for limit_order_book_matcher: queued order/cancel requests, a book
// predictor that computes expected trades and acks, and a field-by-field check.
// Depends on lobm_pkg and the matcher RTL.
module tb_limit_order_book_matcher;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 32;
    localparam int PB    = 16;
    localparam int LIMIT = 200000;

    typedef struct packed {
        logic             cmd;
        logic             is_buy;
        logic [PB-1:0]    price;
        lobm_pkg::qty_t   qty;
        lobm_pkg::id_t    cid;
    } req_t;

    typedef struct packed {
        lobm_pkg::kind_t  kind;
        lobm_pkg::id_t    oid;
        lobm_pkg::qty_t   tqty;
        logic [PB-1:0]    tpx;
        lobm_pkg::id_t    bid;
        lobm_pkg::id_t    sid;
        logic             last;
    } fill_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic cmd = 1'b0;
    logic is_buy = 1'b0;
    logic [PB-1:0] limit_price = '0;
    lobm_pkg::qty_t quantity = '0;
    lobm_pkg::id_t cancel_id = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    lobm_pkg::kind_t kind;
    lobm_pkg::id_t order_id, buy_id, sell_id;
    lobm_pkg::qty_t trade_qty;
    logic [PB-1:0] trade_price;
    logic last;

    limit_order_book_matcher u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // book mirror: index 0 bids, 1 asks
    logic [PB-1:0]  bk_px [2][DEPTH];
    lobm_pkg::qty_t bk_qty[2][DEPTH];
    lobm_pkg::id_t  bk_id [2][DEPTH];
    logic           bk_vd [2][DEPTH];
    lobm_pkg::id_t  next_id;

    req_t  pending[$];
    fill_t expected_fills[$];
    int    errors = 0;
    int    idle_pct = 31;
    bit    hold_send = 0;
    bit    stim_done = 0;
    int    quiet = 0;

    function automatic int best_of(int s, bit want_high);
        int b;
        bit better;
        b = -1;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!bk_vd[s][i]) continue;
            if (b < 0) begin b = i; continue; end
            if (bk_px[s][i] == bk_px[s][b])
                better = (next_id - bk_id[s][i]) > (next_id - bk_id[s][b]);
            else if (want_high)
                better = bk_px[s][i] > bk_px[s][b];
            else
                better = bk_px[s][i] < bk_px[s][b];
            if (better) b = i;
        end
        return b;
    endfunction

    function automatic fill_t mk(lobm_pkg::kind_t k, lobm_pkg::id_t o, lobm_pkg::qty_t q,
                                 logic [PB-1:0] p, lobm_pkg::id_t b, lobm_pkg::id_t s,
                                 logic l);
        fill_t f;
        f.kind = k; f.oid = o; f.tqty = q; f.tpx = p;
        f.bid = b; f.sid = s; f.last = l;
        return f;
    endfunction

    task automatic match_request(req_t r);
        int own, opp, j, f;
        lobm_pkg::id_t id;
        lobm_pkg::qty_t rem, q;
        lobm_pkg::kind_t k;
        if (r.cmd)
        begin
            k = lobm_pkg::KIND_NOT_FOUND;
            for (int s = 0; s < 2 && k == lobm_pkg::KIND_NOT_FOUND; s++)
                for (int i = 0; i < DEPTH; i++)
                    if (bk_vd[s][i] && bk_id[s][i] == r.cid)
                    begin
                        bk_vd[s][i] = 1'b0;
                        k = lobm_pkg::KIND_CANCELLED;
                        break;
                    end
            expected_fills.push_back(mk(k, r.cid, '0, '0, '0, '0, 1'b1));
            return;
        end
        own = r.is_buy ? 0 : 1;
        opp = 1 - own;
        id = next_id;
        next_id = next_id + lobm_pkg::id_t'(1);
        rem = r.qty;
        k = lobm_pkg::KIND_ACCEPT;
        while (rem > 0)
        begin
            j = best_of(opp, !r.is_buy);
            if (j < 0) break;
            if (r.is_buy ? (r.price < bk_px[opp][j]) : (bk_px[opp][j] < r.price)) break;
            q = rem < bk_qty[opp][j] ? rem : bk_qty[opp][j];
            expected_fills.push_back(mk(lobm_pkg::KIND_TRADE, id, q,
                r.is_buy ? bk_px[opp][j] : r.price,
                r.is_buy ? id : bk_id[opp][j], r.is_buy ? bk_id[opp][j] : id, 1'b0));
            bk_qty[opp][j] -= q;
            if (bk_qty[opp][j] == 0) bk_vd[opp][j] = 1'b0;
            rem -= q;
        end
        if (rem > 0)
        begin
            f = -1;
            for (int i = 0; i < DEPTH; i++)
                if (!bk_vd[own][i]) begin f = i; break; end
            if (f >= 0)
            begin
                bk_px[own][f] = r.price; bk_qty[own][f] = rem;
                bk_id[own][f] = id; bk_vd[own][f] = 1'b1;
            end
            else
                k = lobm_pkg::KIND_REJECT;
        end
        expected_fills.push_back(mk(k, id, '0, '0, '0, '0, 1'b1));
    endtask

    function automatic req_t order(bit buy, int px, int q);
        req_t r;
        r.cmd = 1'b0; r.is_buy = buy; r.price = PB'(px); r.qty = lobm_pkg::QTY_W'(q);
        r.cid = {$urandom};
        return r;
    endfunction

    function automatic req_t cancel(lobm_pkg::id_t c);
        req_t r;
        r.cmd = 1'b1; r.is_buy = 1'($urandom); r.price = PB'($urandom);
        r.qty = lobm_pkg::QTY_W'($urandom);
        r.cid = c;
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        req_t r;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
            begin
                match_request({cmd, is_buy, limit_price, quantity, cancel_id});
                void'(pending.pop_front());
            end
            if (!(in_valid && in_stall))
            begin
                if (pending.size() > 0 && !hold_send && $urandom_range(99) >= idle_pct)
                begin
                    r = pending[0];
                    in_valid <= 1'b1;
                    cmd <= r.cmd; is_buy <= r.is_buy; limit_price <= r.price;
                    quantity <= r.qty; cancel_id <= r.cid;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        fill_t got, exp_f;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            out_stall <= ($urandom_range(99) < idle_pct);
            if (in_valid && !in_stall || out_valid && !out_stall) quiet <= 0;
            else quiet <= quiet + 1;
            if (out_valid && !out_stall)
            begin
                got = mk(kind, order_id, trade_qty, trade_price, buy_id, sell_id, last);
                if (expected_fills.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", got);
                end
                else
                begin
                    exp_f = expected_fills.pop_front();
                    if (got !== exp_f)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected %p actual %p", exp_f, got);
                    end
                end
            end
            if (quiet > LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        lobm_pkg::id_t c;
        int px;
        for (int s = 0; s < 2; s++)
            for (int i = 0; i < DEPTH; i++) bk_vd[s][i] = 1'b0;
        next_id = lobm_pkg::FIRST_ID;
        // directed: extremes, both sides, ties, full-book reject, zero qty, cancels
        pending.push_back(order(1, 16'hFFFF, 24'hFFFFFF));
        pending.push_back(order(0, 0, 1));
        pending.push_back(order(0, 16'hFFFF, 24'hFFFFFF));
        pending.push_back(order(1, 100, 5));
        pending.push_back(order(1, 100, 7));
        pending.push_back(order(0, 100, 10));
        pending.push_back(order(1, 0, 0));
        pending.push_back(cancel(2));
        pending.push_back(cancel(2));
        pending.push_back(cancel(32'hFFFFFFFF));
        pending.push_back(cancel(3));
        for (int i = 0; i < 33; i++) pending.push_back(order(0, 60000 + i, 3));
        pending.push_back(order(1, 16'hFFFF, 24'hFFFFFF));
        pending.push_back(order(0, 16'hFFFF, 2));
        #40 rst_n = 1'b1;
        wait (pending.size() == 0);
        hold_send = 1;
        wait (expected_fills.size() == 0);
        hold_send = 0;
        for (int n = 0; n < 320; n++)
        begin
            if (n == 100) idle_pct = 0;
            if (n == 160) idle_pct = 31;
            if ($urandom_range(99) < 22)
            begin
                c = next_id - $urandom_range(1, 40);
                if ($urandom_range(9) == 0) c = {$urandom};
                pending.push_back(cancel(c));
            end
            else
            begin
                px = 1000 + $urandom_range(0, 20) - 10;
                if ($urandom_range(19) == 0) px = $urandom;
                pending.push_back(order(1'($urandom), px,
                    $urandom_range(15) == 0 ? {$urandom} : $urandom_range(0, 40)));
            end
            wait (pending.size() < 4);
        end
        wait (pending.size() == 0 && !in_valid);
        wait (expected_fills.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && expected_fills.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### sim.f
design/lobm_pkg.sv
design/lobm_ram.sv
design/limit_order_book_matcher.sv
verif/tb_limit_order_book_matcher.sv
